// File: hdl/ffgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffgc_pkg
// Shared constants, types and helpers of the flat-field gain calculator.
// ----------------------------------------------------------------------------
package ffgc_pkg;

  // Field widths
  localparam int IN_W       = 16;               // width of one input channel field
  localparam int PIX_BITS   = 16;               // significant pixel bits, 8..16
  localparam int REF_W      = 20;               // reference level, Q16.4
  localparam int GAIN_W     = 20;               // gain, Q8.12
  localparam int NLANES     = 3;                // color channels

  // Divider geometry
  localparam int DEN_W      = PIX_BITS + 2;     // holds the sum of three values
  localparam int NUM_W      = REF_W + 10;       // holds 768 * ref + sum / 2
  localparam int QBITS      = GAIN_W;           // quotient bits, one per stage
  localparam int HI_W       = NUM_W - QBITS;    // numerator bits above the quotient
  localparam int CMP_W      = NUM_W + DEN_W;    // width for the overflow compare
  localparam int PIPE_STAGES = QBITS + 1;       // operand stage plus divider stages

  localparam logic [GAIN_W-1:0] GAIN_MAX   = {GAIN_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(4096);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COMMON = 2'd2;

  localparam logic [REF_W-1:0] REF_RESET = REF_W'(2048);

  typedef struct packed {
    logic [REF_W-1:0] ref_level;
    logic             color;
    logic             common;
  } cfg_t;

  // Operands handed to one divider lane
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } lane_op_t;

  // Raw divider result of one lane
  typedef struct packed {
    logic [QBITS-1:0] quo;
    logic             sat;
    logic             zero;
  } lane_res_t;

  // Map a raw quotient to the final gain
  function automatic logic [GAIN_W-1:0] res_to_gain(lane_res_t res);
    logic [GAIN_W-1:0] g;
    if (res.zero) begin
      g = GAIN_UNITY;
    end else if (res.sat) begin
      g = GAIN_MAX;
    end else begin
      g = GAIN_W'(res.quo);
    end
    return g;
  endfunction

endpackage

// File: hdl/ffgc_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffgc_prep
// Dark subtraction, channel sum and rounded divider operands per lane.
// ----------------------------------------------------------------------------
module ffgc_prep (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  ffgc_pkg::cfg_t                    cfg_i,
  input  logic [ffgc_pkg::IN_W-1:0]         flat_i [ffgc_pkg::NLANES],
  input  logic [ffgc_pkg::IN_W-1:0]         dark_i [ffgc_pkg::NLANES],
  output ffgc_pkg::lane_op_t                op_o   [ffgc_pkg::NLANES]
);
  import ffgc_pkg::*;

  logic [PIX_BITS-1:0] val   [NLANES];
  logic [DEN_W-1:0]    sum;
  logic [NUM_W-1:0]    ref_ext;
  logic [NUM_W-1:0]    num_common;
  lane_op_t            op_d  [NLANES];
  lane_op_t            op_q  [NLANES];

  // Subtract dark level, clamp at zero
  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      if (flat_i[i][PIX_BITS-1:0] > dark_i[i][PIX_BITS-1:0]) begin
        val[i] = flat_i[i][PIX_BITS-1:0] - dark_i[i][PIX_BITS-1:0];
      end else begin
        val[i] = '0;
      end
    end
  end

  // Build numerator and divisor; lane 0 takes the channel sum in common mode
  always_comb begin
    sum        = DEN_W'(val[0]) + DEN_W'(val[1]) + DEN_W'(val[2]);
    ref_ext    = NUM_W'(cfg_i.ref_level);
    num_common = (ref_ext << 9) + (ref_ext << 8) + NUM_W'(sum >> 1);
    for (int i = 0; i < NLANES; i++) begin
      op_d[i].num = (ref_ext << 8) + NUM_W'(val[i] >> 1);
      op_d[i].den = DEN_W'(val[i]);
    end
    if (cfg_i.color && cfg_i.common) begin
      op_d[0].num = num_common;
      op_d[0].den = sum;
    end
  end

  // Hold operands while the next stage is stalled
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NLANES; i++) begin
      if (en_i) begin
        op_q[i] <= op_d[i];
      end
    end
  end

  assign op_o = op_q;

endmodule

// File: hdl/ffgc_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffgc_div_lane
// Pipelined restoring divider, one quotient bit per stage, with overflow
// and zero-divisor detection in the first stage.
// ----------------------------------------------------------------------------
module ffgc_div_lane (
  input  logic                          clk_i,
  input  logic [ffgc_pkg::QBITS-1:0]    en_i,
  input  ffgc_pkg::lane_op_t            op_i,
  output ffgc_pkg::lane_res_t           res_o
);
  import ffgc_pkg::*;

  logic [DEN_W-1:0] rem_q  [QBITS];
  logic [QBITS-1:0] low_q  [QBITS];
  logic [QBITS-1:0] quo_q  [QBITS];
  logic [DEN_W-1:0] den_q  [QBITS];
  logic             sat_q  [QBITS];
  logic             zero_q [QBITS];

  logic [DEN_W-1:0] src_rem  [QBITS];
  logic [QBITS-1:0] src_low  [QBITS];
  logic [QBITS-1:0] src_quo  [QBITS];
  logic [DEN_W-1:0] src_den  [QBITS];
  logic             src_sat  [QBITS];
  logic             src_zero [QBITS];

  logic [DEN_W-1:0] rem_d  [QBITS];
  logic [QBITS-1:0] quo_d  [QBITS];

  logic [DEN_W:0]   trial  [QBITS];
  logic             ge     [QBITS];

  // Select stage sources: the first stage starts from the operands
  always_comb begin
    for (int j = 0; j < QBITS; j++) begin
      if (j == 0) begin
        src_rem[j]  = DEN_W'(op_i.num[NUM_W-1:QBITS]);
        src_low[j]  = op_i.num[QBITS-1:0];
        src_quo[j]  = '0;
        src_den[j]  = op_i.den;
        src_zero[j] = (op_i.den == '0);
        src_sat[j]  = (op_i.den != '0) &&
                      (CMP_W'(op_i.num[NUM_W-1:QBITS]) >= CMP_W'(op_i.den));
      end else begin
        src_rem[j]  = rem_q[j-1];
        src_low[j]  = low_q[j-1];
        src_quo[j]  = quo_q[j-1];
        src_den[j]  = den_q[j-1];
        src_zero[j] = zero_q[j-1];
        src_sat[j]  = sat_q[j-1];
      end
    end
  end

  // Shift in the next numerator bit, subtract the divisor where it fits
  always_comb begin
    for (int j = 0; j < QBITS; j++) begin
      trial[j] = {src_rem[j], src_low[j][QBITS-1]};
      ge[j]    = trial[j] >= {1'b0, src_den[j]};
      if (ge[j]) begin
        rem_d[j] = DEN_W'(trial[j] - {1'b0, src_den[j]});
      end else begin
        rem_d[j] = DEN_W'(trial[j]);
      end
      quo_d[j] = {src_quo[j][QBITS-2:0], ge[j]};
    end
  end

  // Advance each stage when its slot is free or moving on
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QBITS; j++) begin
      if (en_i[j]) begin
        rem_q[j]  <= rem_d[j];
        low_q[j]  <= src_low[j] << 1;
        quo_q[j]  <= quo_d[j];
        den_q[j]  <= src_den[j];
        sat_q[j]  <= src_sat[j];
        zero_q[j] <= src_zero[j];
      end
    end
  end

  assign res_o.quo  = quo_q[QBITS-1];
  assign res_o.sat  = sat_q[QBITS-1];
  assign res_o.zero = zero_q[QBITS-1];

endmodule

// File: hdl/ffgc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffgc_merge
// Combines the lane results into the output gains and saturation flag and
// holds them in the output register.
// ----------------------------------------------------------------------------
module ffgc_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ffgc_pkg::cfg_t                 cfg_i,
  input  logic                           vld_i,
  input  logic                           ld_i,
  input  ffgc_pkg::lane_res_t            res_i  [ffgc_pkg::NLANES],
  output logic                           vld_o,
  output logic [ffgc_pkg::GAIN_W-1:0]    gain_o [ffgc_pkg::NLANES],
  output logic                           sat_o
);
  import ffgc_pkg::*;

  logic              vld_q;
  logic [GAIN_W-1:0] gain_d [NLANES];
  logic [GAIN_W-1:0] gain_q [NLANES];
  logic              sat_d;
  logic              sat_q;
  logic              shared;

  // Lane 0 feeds all channels in mono and common modes
  always_comb begin
    shared = !cfg_i.color || cfg_i.common;
    for (int i = 0; i < NLANES; i++) begin
      if (shared) begin
        gain_d[i] = res_to_gain(res_i[0]);
      end else begin
        gain_d[i] = res_to_gain(res_i[i]);
      end
    end
    sat_d = res_i[0].sat && !res_i[0].zero;
    if (!shared) begin
      for (int i = 1; i < NLANES; i++) begin
        sat_d = sat_d || (res_i[i].sat && !res_i[i].zero);
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ld_i) begin
      vld_q <= vld_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      gain_q <= gain_d;
      sat_q  <= sat_d;
    end
  end

  assign vld_o  = vld_q;
  assign gain_o = gain_q;
  assign sat_o  = sat_q;

endmodule

// File: hdl/flat_field_gain_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_field_gain_calc
// Flat-field lens shading gain: dark-subtracts one pixel of up to three
// channels and returns Q8.12 gains ref / value, per channel or common.
// ----------------------------------------------------------------------------
// Channel   | Direction | Contents
// s_axis    | in        | flat c0..c2, dark c0..c2 (16 bits each)
// m_axis    | out       | gain c0..c2 (20 bits each), saturation flag
// cfg       | in        | reference_level, color_mode, common_gain_mode
//
// One transaction per cycle sustained while the output is not stalled. Input
// passes through one operand stage, the 20-stage divider (one quotient bit per
// stage) and the output register. Each stage advances when any stage from it
// onward is empty or the output drains, so a stalled output only stops the
// full stages behind it. Reset clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module flat_field_gain_calc (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // flat_c0, flat_c1, flat_c2, dark_c0, dark_c1, dark_c2 (lowest bits first)
  input  logic [95:0]                    s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // gain_c0, gain_c1, gain_c2, gain_saturated, 3 zero bits (lowest bits first)
  output logic [63:0]                    m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [ffgc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ffgc_pkg::REF_W-1:0]     cfg_wdata_i
);
  import ffgc_pkg::*;

  cfg_t              cfg_q;
  logic [PIPE_STAGES-1:0] vld_q;
  logic [PIPE_STAGES-1:0] rdy;
  logic              out_rdy;
  logic [IN_W-1:0]   flat   [NLANES];
  logic [IN_W-1:0]   dark   [NLANES];
  lane_op_t          op     [NLANES];
  lane_res_t         res    [NLANES];
  logic [GAIN_W-1:0] gain   [NLANES];
  logic              sat;
  logic              out_vld;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_level <= REF_RESET;
      cfg_q.color     <= 1'b1;
      cfg_q.common    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_REF:    cfg_q.ref_level <= cfg_wdata_i;
        CFG_IDX_COLOR:  cfg_q.color     <= cfg_wdata_i[0];
        CFG_IDX_COMMON: cfg_q.common    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Unpack input fields
  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      flat[i] = s_axis_tdata[i*IN_W +: IN_W];
      dark[i] = s_axis_tdata[(i+NLANES)*IN_W +: IN_W];
    end
  end

  // Stage k may load when any stage from k onward is empty or output drains
  assign out_rdy = !out_vld || m_axis_tready;
  always_comb begin
    for (int k = 0; k < PIPE_STAGES; k++) begin
      rdy[k] = out_rdy ||
               !(&(vld_q | PIPE_STAGES'((64'd1 << k) - 64'd1)));
    end
  end

  // Valid flags ride along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        if (rdy[k]) begin
          if (k == 0) begin
            vld_q[k] <= s_axis_tvalid;
          end else begin
            vld_q[k] <= vld_q[k-1];
          end
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];

  ffgc_prep u_prep (
    .clk_i  (clk_i),
    .en_i   (rdy[0]),
    .cfg_i  (cfg_q),
    .flat_i (flat),
    .dark_i (dark),
    .op_o   (op)
  );

  for (genvar g = 0; g < NLANES; g++) begin : g_lane
    ffgc_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (rdy[PIPE_STAGES-1:1]),
      .op_i  (op[g]),
      .res_o (res[g])
    );
  end

  ffgc_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .vld_i  (vld_q[PIPE_STAGES-1]),
    .ld_i   (out_rdy),
    .res_i  (res),
    .vld_o  (out_vld),
    .gain_o (gain),
    .sat_o  (sat)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {3'b000, sat, gain[2], gain[1], gain[0]};

  // An accepted transaction lands in the operand stage
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted transaction did not enter the operand stage");

  // A new result only appears from a valid last divider stage
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[PIPE_STAGES-1]))
    else $error("output valid without a finished divider stage");

  // A saturated result carries at least one clipped gain
  a_sat_gain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && sat) |->
      (gain[0] == GAIN_MAX || gain[1] == GAIN_MAX || gain[2] == GAIN_MAX))
    else $error("saturation flag without a clipped gain");

  // A full pipeline with a stalled output takes nothing
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while pipeline is full and stalled");

endmodule
